### rtl/core/zbfs_pkg.sv
`timescale 1ns / 1ps

package zbfs_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int CNT_W       = ADDR_W + 1;

    localparam int GEO_W   = 11;
    localparam int COORD_W = 12;
    localparam int DATA_W  = 32;
    localparam int KIND_W  = 3;
    localparam int PROD_W  = 2 * GEO_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [GEO_W-1:0]  RESET_WIDTH  = GEO_W'(1024);
    localparam logic [GEO_W-1:0]  RESET_HEIGHT = GEO_W'(1024);
    localparam logic [DATA_W-1:0] OOB_COLOR    = 32'hFFFF00FF;
    localparam logic [DATA_W-1:0] CLEAR_DEPTH  = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        K_ZTEST    = 3'd0,
        K_COLOR_WR = 3'd1,
        K_DEPTH_WR = 3'd2,
        K_READ     = 3'd3,
        K_CLEAR    = 3'd4,
        K_FILL     = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_ACCESS,
        S_CHECK,
        S_SWEEP,
        S_RESULT
    } t_state;

endpackage

### rtl/core/zbfs_ram.sv
`timescale 1ns / 1ps

module zbfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/zbuffer_fragment_store_top.sv
`timescale 1ns / 1ps

// Framebuffer with a color store and a depth store, one 32-bit word per pixel each, addressed
// bottom-up as (height-1-v)*width+u. One item is in work at a time. A depth-tested write or a
// read passes through ADDR (bounds and the row-times-width multiply), ACCESS (address add and
// memory read), CHECK (depth compare and write-back, or for a read the capture of the color)
// and RESULT (the result is posted once the output register is free). A color write or depth
// write needs no compare step and goes from ACCESS, where it writes, to RESULT. A clear or fill
// walks the image one word a cycle through the memory write port. The next item is taken while
// a result still waits at the output. Depth is unsigned Q16.16 (larger is nearer); an equal
// depth passes the test. The user must write width and height only while the block is idle;
// the block itself does not enforce this. Values above the store size saturate.
module zbuffer_fragment_store_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [zbfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [zbfs_pkg::GEO_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [zbfs_pkg::KIND_W-1:0]    i_kind,
    input  logic signed [zbfs_pkg::COORD_W-1:0] i_u,
    input  logic signed [zbfs_pkg::COORD_W-1:0] i_v,
    input  logic [zbfs_pkg::DATA_W-1:0]    i_depth,
    input  logic [zbfs_pkg::DATA_W-1:0]    i_color,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [zbfs_pkg::DATA_W-1:0]    o_read_color,
    output logic                           o_written,
    output logic                           o_in_bounds
);

    import zbfs_pkg::*;

    t_state                    r_state, n_state;
    logic [KIND_W-1:0]         r_kind;
    logic [COORD_W-1:0]        r_u, r_v;
    logic [DATA_W-1:0]         r_depth, r_color;
    logic [GEO_W-1:0]          r_width, r_height;
    logic                      r_inb, n_inb;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic [ADDR_W-1:0]         r_addr, n_addr;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [DATA_W-1:0]         r_res_color, n_res_color;
    logic                      r_res_written, n_res_written;
    logic                      r_o_valid, n_o_valid;
    logic [DATA_W-1:0]         r_o_color;
    logic                      r_o_written, r_o_inb;

    logic [GEO_W-1:0]  w_eff, h_eff, row, mul_a;
    logic              u_ok, v_ok, is_pixel, in_xfer, load_out;
    logic [ADDR_W-1:0] addr_sum, raddr, waddr;
    logic              c_we, d_we;
    logic [DATA_W-1:0] d_wdata, c_rdata, d_rdata;

    // geometry and bounds
    always_comb begin
        w_eff = (int'(r_width) > MAX_WIDTH) ? GEO_W'(MAX_WIDTH) : r_width;
        h_eff = (int'(r_height) > MAX_HEIGHT) ? GEO_W'(MAX_HEIGHT) : r_height;
        u_ok  = !r_u[COORD_W-1] && (r_u[GEO_W-1:0] < w_eff);
        v_ok  = !r_v[COORD_W-1] && (r_v[GEO_W-1:0] < h_eff);
        row   = h_eff - GEO_W'(1) - r_v[GEO_W-1:0];
        is_pixel = r_kind inside {K_ZTEST, K_COLOR_WR, K_DEPTH_WR, K_READ};
        mul_a = is_pixel ? row : h_eff;
        addr_sum = r_prod[ADDR_W-1:0] + ADDR_W'(r_u[GEO_W-1:0]);
    end

    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_width   <= RESET_WIDTH;
            r_height  <= RESET_HEIGHT;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind  <= i_kind;
            r_u     <= i_u;
            r_v     <= i_v;
            r_depth <= i_depth;
            r_color <= i_color;
        end
        r_inb         <= n_inb;
        r_prod        <= n_prod;
        r_addr        <= n_addr;
        r_cnt         <= n_cnt;
        r_res_color   <= n_res_color;
        r_res_written <= n_res_written;
        if (load_out) begin
            r_o_color   <= r_res_color;
            r_o_written <= r_res_written;
            r_o_inb     <= r_inb;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_inb         = r_inb;
        n_prod        = r_prod;
        n_addr        = r_addr;
        n_cnt         = r_cnt;
        n_res_color   = r_res_color;
        n_res_written = r_res_written;
        load_out      = 1'b0;
        n_o_valid     = r_o_valid && !i_out_ready;
        c_we          = 1'b0;
        d_we          = 1'b0;
        raddr         = addr_sum;
        waddr         = r_addr;
        d_wdata       = r_depth;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_prod        = PROD_W'(mul_a * w_eff);
                n_inb         = is_pixel && u_ok && v_ok;
                n_res_color   = '0;
                n_res_written = 1'b0;
                n_cnt         = '0;
                if (is_pixel) begin
                    n_state = S_ACCESS;
                end else if (r_kind == K_CLEAR || r_kind == K_FILL) begin
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_ACCESS: begin
                n_addr = addr_sum;
                waddr  = addr_sum;
                case (r_kind)
                    K_COLOR_WR: begin
                        c_we          = r_inb;
                        n_res_written = r_inb;
                        n_state       = S_RESULT;
                    end
                    K_DEPTH_WR: begin
                        d_we          = r_inb;
                        n_res_written = r_inb;
                        n_state       = S_RESULT;
                    end
                    default: begin
                        n_state = S_CHECK;
                    end
                endcase
            end
            S_CHECK: begin
                if (r_kind == K_ZTEST) begin
                    c_we          = r_inb && (r_depth >= d_rdata);
                    d_we          = c_we;
                    n_res_written = c_we;
                end else begin
                    n_res_color = r_inb ? c_rdata : OOB_COLOR;
                end
                n_state = S_RESULT;
            end
            S_SWEEP: begin
                waddr   = r_cnt[ADDR_W-1:0];
                d_wdata = CLEAR_DEPTH;
                if (r_cnt == r_prod[CNT_W-1:0]) begin
                    n_res_written = (r_prod != '0);
                    n_state       = S_RESULT;
                end else begin
                    c_we  = (r_kind == K_FILL);
                    d_we  = (r_kind == K_CLEAR);
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_RESULT: begin
                if (!r_o_valid || i_out_ready) begin
                    load_out  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    zbfs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STORE_WORDS)
    ) u_color_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(waddr),
        .i_wdata(r_color),
        .i_raddr(raddr),
        .o_rdata(c_rdata)
    );

    zbfs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STORE_WORDS)
    ) u_depth_ram (
        .i_clk  (i_clk),
        .i_we   (d_we),
        .i_waddr(waddr),
        .i_wdata(d_wdata),
        .i_raddr(raddr),
        .o_rdata(d_rdata)
    );

    assign o_out_valid  = r_o_valid;
    assign o_read_color = r_o_color;
    assign o_written    = r_o_written;
    assign o_in_bounds  = r_o_inb;

endmodule

### rtl/core/zbfs_checker.sv
`timescale 1ns / 1ps

module zbfs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [zbfs_pkg::DATA_W-1:0]    o_read_color,
    input logic                           o_written,
    input logic                           o_in_bounds
);

    import zbfs_pkg::*;

    logic [1:0] r_pending;
    logic       in_xfer, out_xfer;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    // items taken whose result is not yet transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(in_xfer) - 2'(out_xfer);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_read_color) && $stable(o_written) && $stable(o_in_bounds))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 2'd0)
        else $error("result without a pending item");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3 && !(r_pending == 2'd2 && o_in_ready))
        else $error("more items in flight than the block holds");

endmodule

bind zbuffer_fragment_store_top zbfs_checker u_zbfs_checker (.*);
